>>> rtl/pdfd_pkg.sv
// Shared types and constants for the pulse-distance frame decoder.
// No dependencies; every module of the block imports this package.
package pdfd_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ByteW  = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_BIT_MIN   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BIT_MAX   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BIT_SPLIT = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BEGIN_MIN = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BEGIN_MAX = 3'd4;

  // Reset values of the interval windows, in microseconds
  localparam logic [CfgW-1:0] BIT_MIN_RST   = 16'(256 * 6 * 3 + 16);
  localparam logic [CfgW-1:0] BIT_MAX_RST   = 16'(2048 * 6 + 512 * 6 + 256 * 6);
  localparam logic [CfgW-1:0] BIT_SPLIT_RST = 16'(1024 * 6 + 512 * 6 + 8);
  localparam logic [CfgW-1:0] BEGIN_MIN_RST = 16'(8192 * 6 - 256 * 6);
  localparam logic [CfgW-1:0] BEGIN_MAX_RST = 16'(8192 * 6 + 512 * 6 + 256 * 6);

  typedef struct packed {
    logic [CfgW-1:0] bit_min_us;
    logic [CfgW-1:0] bit_max_us;
    logic [CfgW-1:0] bit_split_us;
    logic [CfgW-1:0] begin_min_us;
    logic [CfgW-1:0] begin_max_us;
  } cfg_t;

  typedef enum logic [1:0] {
    TOK_DROP  = 2'd0,
    TOK_BIT   = 2'd1,
    TOK_BEGIN = 2'd2
  } tok_kind_t;

  // One classified interval handed from the front end to the back end
  typedef struct packed {
    tok_kind_t kind;
    logic      bit_val;
  } token_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] byte_index;
    logic [ByteW-1:0] frame_length;
    logic             is_last;
    logic             is_empty;
  } result_t;

endpackage

>>> rtl/pdfd_front.sv
// Front end: holds the window registers and the previous edge time,
// and classifies each edge interval into a token. Depends on pdfd_pkg.
module pdfd_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pdfd_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [pdfd_pkg::CfgW-1:0]      cfg_data,
  input  logic                           take,
  input  logic [pdfd_pkg::TimeW-1:0]     edge_time_us,
  output pdfd_pkg::token_t               tok
);
  import pdfd_pkg::*;

  cfg_t             cfg;
  logic [TimeW-1:0] previous_edge;
  logic [TimeW-1:0] delta;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_min_us   <= BIT_MIN_RST;
      cfg.bit_max_us   <= BIT_MAX_RST;
      cfg.bit_split_us <= BIT_SPLIT_RST;
      cfg.begin_min_us <= BEGIN_MIN_RST;
      cfg.begin_max_us <= BEGIN_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIT_MIN:   cfg.bit_min_us   <= cfg_data;
        REG_BIT_MAX:   cfg.bit_max_us   <= cfg_data;
        REG_BIT_SPLIT: cfg.bit_split_us <= cfg_data;
        REG_BEGIN_MIN: cfg.begin_min_us <= cfg_data;
        REG_BEGIN_MAX: cfg.begin_max_us <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_edge <= '0;
    end else if (take) begin
      previous_edge <= edge_time_us;
    end
  end

  // Interval wraps modulo 2^32
  assign delta = edge_time_us - previous_edge;

  always_comb begin
    tok.bit_val = (delta > {16'd0, cfg.bit_split_us});
    priority if (delta > {16'd0, cfg.begin_max_us}) begin
      tok.kind = TOK_DROP;
    end else if (delta <= {16'd0, cfg.bit_max_us}) begin
      tok.kind = (delta < {16'd0, cfg.bit_min_us}) ? TOK_DROP : TOK_BIT;
    end else if (delta < {16'd0, cfg.begin_min_us}) begin
      tok.kind = TOK_DROP;
    end else begin
      tok.kind = TOK_BEGIN;
    end
  end

endmodule

>>> rtl/pdfd_tok_q.sv
// Two-entry queue of classified tokens between front and back end.
// Depends on pdfd_pkg.
module pdfd_tok_q (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  pdfd_pkg::token_t wr_data,
  output logic             full,
  input  logic             rd,
  output pdfd_pkg::token_t rd_data,
  output logic             empty
);
  import pdfd_pkg::*;

  token_t     entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr && !full) wr_ptr <= ~wr_ptr;
      if (rd && !empty) rd_ptr <= ~rd_ptr;
      unique case ({wr && !full, rd && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/pdfd_back.sv
// Back end: assembles bits into bytes, tracks frame length and index,
// and produces result requests. Depends on pdfd_pkg.
module pdfd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              tok_valid,
  input  pdfd_pkg::token_t  tok,
  input  logic              res_full,
  output logic              tok_take,
  output logic              res_wr,
  output pdfd_pkg::result_t res
);
  import pdfd_pkg::*;

  logic             receiving,        receiving_next;
  logic             length_known,     length_known_next;
  logic [ByteW-1:0] announced_length, announced_length_next;
  logic [ByteW-1:0] shift_byte,       shift_byte_next;
  logic [2:0]       bit_count,        bit_count_next;
  logic [ByteW-1:0] byte_count,       byte_count_next;
  logic             last;

  // Stall while the result queue has no room
  assign tok_take = tok_valid && !res_full;

  always_comb begin
    receiving_next        = receiving;
    length_known_next     = length_known;
    announced_length_next = announced_length;
    shift_byte_next       = shift_byte;
    bit_count_next        = bit_count;
    byte_count_next       = byte_count;
    res_wr                = 1'b0;
    res                   = '0;
    last                  = ((byte_count + 8'd1) == announced_length);
    if (tok_take) begin
      unique case (tok.kind)
        TOK_DROP: begin
          receiving_next = 1'b0;
        end
        TOK_BEGIN: begin
          receiving_next        = 1'b1;
          length_known_next     = 1'b0;
          announced_length_next = '0;
          shift_byte_next       = '0;
          bit_count_next        = '0;
          byte_count_next       = '0;
        end
        TOK_BIT: begin
          if (receiving) begin
            shift_byte_next = {shift_byte[ByteW-2:0], tok.bit_val};
            bit_count_next  = bit_count + 3'd1;
            if (bit_count == 3'd7) begin
              if (length_known) begin
                res_wr              = 1'b1;
                res.data_byte       = shift_byte_next;
                res.byte_index      = byte_count;
                res.frame_length    = announced_length;
                res.is_last         = last;
                byte_count_next     = byte_count + 8'd1;
                if (last) receiving_next = 1'b0;
              end else begin
                announced_length_next = shift_byte_next;
                length_known_next     = 1'b1;
                // Zero length: emit one empty result and close the frame
                if (shift_byte_next == '0) begin
                  res_wr         = 1'b1;
                  res.is_last    = 1'b1;
                  res.is_empty   = 1'b1;
                  receiving_next = 1'b0;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving        <= 1'b0;
      length_known     <= 1'b0;
      announced_length <= '0;
      shift_byte       <= '0;
      bit_count        <= '0;
      byte_count       <= '0;
    end else begin
      receiving        <= receiving_next;
      length_known     <= length_known_next;
      announced_length <= announced_length_next;
      shift_byte       <= shift_byte_next;
      bit_count        <= bit_count_next;
      byte_count       <= byte_count_next;
    end
  end

endmodule

>>> rtl/pdfd_res_q.sv
// Two-entry output queue holding finished results until popped.
// Depends on pdfd_pkg.
module pdfd_res_q (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  pdfd_pkg::result_t wr_data,
  output logic              full,
  input  logic              rd,
  output pdfd_pkg::result_t rd_data,
  output logic              empty
);
  import pdfd_pkg::*;

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr && !full) wr_ptr <= ~wr_ptr;
      if (rd && !empty) rd_ptr <= ~rd_ptr;
      unique case ({wr && !full, rd && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/pulse_distance_frame_decoder.sv
// Pulse-distance frame decoder, top level.
// An accepted timestamp's token is registered in the token queue; the back end
// takes it while the result queue has room and writes its result into that queue.
// Throughput: one edge per cycle while full is low; the classify step and the
// byte-assembly step are coupled by a two-entry token queue.
// Reset (rst, synchronous): windows return to defaults, previous edge to 0,
// frame state to idle, both queues empty.
module pulse_distance_frame_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [pdfd_pkg::TimeW-1:0]    edge_time_us,
  input  logic                          pop,
  output logic                          empty,
  output logic [pdfd_pkg::ByteW-1:0]    data_byte,
  output logic [pdfd_pkg::ByteW-1:0]    byte_index,
  output logic [pdfd_pkg::ByteW-1:0]    frame_length,
  output logic                          is_last,
  output logic                          is_empty,
  input  logic                          cfg_we,
  input  logic [pdfd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pdfd_pkg::CfgW-1:0]     cfg_data
);
  import pdfd_pkg::*;

  token_t  front_tok;
  token_t  back_tok;
  logic    tok_full;
  logic    tok_empty;
  logic    tok_take;
  logic    take;
  logic    res_wr;
  logic    res_full;
  result_t res_in;
  result_t res_out;

  assign full = tok_full;
  assign take = push && !tok_full;

  pdfd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .take         (take),
    .edge_time_us (edge_time_us),
    .tok          (front_tok)
  );

  pdfd_tok_q u_tok_q (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_data (front_tok),
    .full    (tok_full),
    .rd      (tok_take),
    .rd_data (back_tok),
    .empty   (tok_empty)
  );

  pdfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (!tok_empty),
    .tok       (back_tok),
    .res_full  (res_full),
    .tok_take  (tok_take),
    .res_wr    (res_wr),
    .res       (res_in)
  );

  pdfd_res_q u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_wr),
    .wr_data (res_in),
    .full    (res_full),
    .rd      (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign data_byte    = res_out.data_byte;
  assign byte_index   = res_out.byte_index;
  assign frame_length = res_out.frame_length;
  assign is_last      = res_out.is_last;
  assign is_empty     = res_out.is_empty;

endmodule
